// ----- hw/rtl/scrc_pkg.sv -----
// shared types and constants for the sample count rate controller
`default_nettype none

package scrc_pkg;

    // default upper bound on samples per pixel
    localparam int MAX_SAMPLES_DEF = 2048;
    // the count is 12 bits wide, so it never exceeds this
    localparam int SPP_CAP         = 4095;

    localparam int SPP_W    = 12;
    localparam int TIME_W   = 16;
    localparam int SMOOTH_W = 24;
    localparam int FPS_W    = 9;

    // q16 constants
    localparam logic [16:0] ALPHA_Q16     = 17'd5243;
    localparam logic [16:0] KEEP_Q16      = 17'd60293;
    localparam logic [16:0] STEP_DOWN_Q16 = 17'd60293;
    localparam logic [16:0] STEP_UP_Q16   = 17'd73400;
    localparam logic [31:0] ONE_Q16       = 32'd65536;
    localparam logic [31:0] DEAD_BAND_Q16 = 32'd6554;

    localparam logic [FPS_W-1:0] FPS_DEFAULT = 9'd60;
    localparam logic [6:0]       HOLD_MIN    = 7'd6;
    // fps / 5 as (fps * 205) >> 10, exact for 9-bit fps
    localparam logic [7:0]       DIV5_RECIP  = 8'd205;

    // ratio divider: (950 << 32 + den / 2) / den
    localparam int DIV_NUM_W = 43;
    localparam int DIV_DEN_W = 33;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);
    localparam logic [DIV_NUM_W-1:0] BUDGET_NUM = 43'd950 << 32;

    // configuration register indexes
    localparam logic CFG_ENABLE     = 1'b0;
    localparam logic CFG_TARGET_FPS = 1'b1;

    typedef enum logic [2:0] {
        STAT_DISABLED  = 3'd0,
        STAT_NO_MEAS   = 3'd1,
        STAT_HOLDOFF   = 3'd2,
        STAT_DEAD_BAND = 3'd3,
        STAT_ADJUSTED  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_AVG_A,
        ST_AVG_B,
        ST_HOLD,
        ST_DEN,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_BAND,
        ST_MUL_V,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_FINISH,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/scrc_div.sv -----
// restoring divider, one quotient bit per cycle
`default_nettype none

module scrc_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [scrc_pkg::DIV_NUM_W-1:0] i_dividend,
    input  wire logic [scrc_pkg::DIV_DEN_W-1:0] i_divisor,
    output logic                                o_done,
    output logic      [scrc_pkg::DIV_NUM_W-1:0] o_quotient
);
    import scrc_pkg::*;

    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_DEN_W:0]   w_shift;
    logic [DIV_DEN_W:0]   w_diff;
    logic                 w_ge;
    logic [DIV_DEN_W-1:0] n_rem;

    always_comb begin
        w_shift = {r_rem, r_quo[DIV_NUM_W-1]};
        w_ge    = w_shift >= {1'b0, r_den};
        w_diff  = w_shift - {1'b0, r_den};
        // the partial remainder stays below the divisor
        n_rem   = w_ge ? w_diff[DIV_DEN_W-1:0] : w_shift[DIV_DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NUM_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ----- hw/rtl/sample_count_rate_controller.sv -----
// samples-per-pixel rate controller: top level with sequencer and shared multiplier
//
// One input beat per rendered frame carries render time, frame time (both in
// 1/256 ms, render time zero means absent) and a fast-adapt load. Each beat
// yields exactly one output beat with the new samples-per-pixel count, a
// changed flag and a status code. The config channel writes enable (index 0)
// and target fps (index 1); it is always ready and is meant to be used while
// no beat is in flight.
// An adjusted beat goes through check, averaging, hold, denominator, divide,
// dead band, multiply and finish states to done; the 43-step ratio divider
// dominates this. Seeding skips averaging, dead-band holds end after the band
// state, hold-offs after hold, disabled or no-measurement beats after check.
// One beat is worked on at a time; o_ready is high only in the idle state,
// which comes back as o_valid rises. The finished result sits in an output
// register, so the next input beat can be taken while the receiver stalls;
// a second result then waits in the sequencer, with o_ready low, until the
// output register frees up.
// Reset (synchronous, active low) sets enable, fps 60, count 8 and clears the
// smoothed time, hold-off and fast-adapt counters.
`default_nettype none

module sample_count_rate_controller #(
    parameter int MAX_SAMPLES = scrc_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_render_time,
    input  wire logic [15:0] i_frame_time,
    input  wire logic [7:0]  i_fast_adapt_load,
    // output channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [11:0]      o_samples_per_pixel,
    output logic             o_changed,
    output logic [2:0]       o_status,
    // configuration channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [8:0]  i_cfg_data
);
    import scrc_pkg::*;

    localparam logic [SPP_W-1:0] SPP_LIMIT =
        (MAX_SAMPLES > SPP_CAP) ? SPP_W'(SPP_CAP) : SPP_W'(MAX_SAMPLES);
    localparam logic [43:0] V_MIN = 44'(ONE_Q16);
    localparam logic [43:0] V_MAX = 44'({SPP_LIMIT, 16'h0000});

    t_state r_state;
    t_state n_state;

    // configuration
    logic             r_enable;
    logic [FPS_W-1:0] r_target_fps;

    // controller state
    logic [SMOOTH_W-1:0] r_smooth;
    logic [6:0]          r_holdoff;
    logic [SPP_W-1:0]    r_spp;
    logic [7:0]          r_fast_cnt;

    // per-beat working registers
    logic [TIME_W-1:0]    r_render;
    logic [TIME_W-1:0]    r_frame;
    logic [7:0]           r_load;
    logic [TIME_W-1:0]    r_meas;
    logic                 r_fast;
    logic [39:0]          r_acc;
    logic [DIV_DEN_W-1:0] r_den;
    logic [31:0]          r_ratio;
    logic [43:0]          r_v;
    t_status              r_res_status;
    logic                 r_res_changed;

    // output register
    logic             r_out_valid;
    logic [SPP_W-1:0] r_out_spp;
    logic             r_out_changed;
    t_status          r_out_status;

    // shared multiplier
    logic [31:0] w_mul_a;
    logic [23:0] w_mul_b;
    logic [55:0] w_prod;

    logic                 w_div_start;
    logic                 w_div_done;
    logic [DIV_NUM_W-1:0] w_quo;
    logic [DIV_NUM_W-1:0] w_dividend;
    logic [DIV_DEN_W-1:0] w_divisor;

    logic             w_in_acc;
    logic             w_out_acc;
    logic             w_out_free;
    logic [FPS_W-1:0] w_fps;
    logic [7:0]       w_fast_eff;
    logic [TIME_W-1:0] w_meas;
    logic [40:0]      w_avg_sum;
    logic [31:0]      w_band_diff;
    logic [16:0]      w_div5;
    logic [6:0]       w_hold;
    logic [43:0]      w_v_lo;
    logic [43:0]      w_v_cl;
    logic [43:0]      w_round;
    logic [SPP_W-1:0] w_next0;
    logic [SPP_W-1:0] w_next1;
    logic [SPP_W-1:0] w_next;

    assign w_in_acc   = i_valid && o_ready;
    assign w_out_acc  = r_out_valid && i_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign o_cfg_ready = 1'b1;

    assign w_fps      = (r_target_fps != '0) ? r_target_fps : FPS_DEFAULT;
    assign w_fast_eff = (r_load != 8'd0) ? r_load : r_fast_cnt;
    assign w_meas     = (r_render != '0) ? r_render : r_frame;

    assign w_prod    = w_mul_a * w_mul_b;
    assign w_avg_sum = {1'b0, r_acc} + {1'b0, w_prod[39:0]} + 41'd32768;

    assign w_band_diff = (r_ratio >= ONE_Q16) ? (r_ratio - ONE_Q16) : (ONE_Q16 - r_ratio);

    assign w_div5 = {8'd0, w_fps} * {9'd0, DIV5_RECIP};
    assign w_hold = (w_div5[16:10] < HOLD_MIN) ? HOLD_MIN : w_div5[16:10];

    // rounding: (num + den / 2) / den, a zero divisor acts as one
    assign w_divisor  = (r_den == '0) ? DIV_DEN_W'(1) : r_den;
    assign w_dividend = BUDGET_NUM + {11'd0, w_divisor[DIV_DEN_W-1:1]};

    always_comb begin
        w_v_lo  = (r_v < V_MIN) ? V_MIN : r_v;
        w_v_cl  = (w_v_lo > V_MAX) ? V_MAX : w_v_lo;
        w_round = w_v_cl + 44'd32768;
        w_next0 = w_round[27:16];
        w_next1 = (w_next0 > SPP_LIMIT) ? SPP_LIMIT : w_next0;
        w_next  = w_next1;
        // nudge by one when rounding leaves the count where it was
        if (w_next1 == r_spp && r_ratio > ONE_Q16 && r_spp < SPP_LIMIT) begin
            w_next = r_spp + 1'b1;
        end else if (w_next1 == r_spp && r_ratio < ONE_Q16 && r_spp > SPP_W'(1)) begin
            w_next = r_spp - 1'b1;
        end
    end

    scrc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!r_enable || w_meas == '0) begin
                    n_state = ST_DONE;
                end else if (w_fast_eff != 8'd0 || r_smooth == '0) begin
                    n_state = ST_HOLD;
                end else begin
                    n_state = ST_AVG_A;
                end
            end
            ST_AVG_A:    n_state = ST_AVG_B;
            ST_AVG_B:    n_state = ST_HOLD;
            ST_HOLD: begin
                if (!r_fast && r_holdoff != '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DEN;
                end
            end
            ST_DEN:      n_state = ST_DIV_GO;
            ST_DIV_GO:   n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_BAND;
                end
            end
            ST_BAND: begin
                if (w_band_diff < DEAD_BAND_Q16) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MUL_V;
                end
            end
            ST_MUL_V:    n_state = ST_MUL_LO;
            ST_MUL_LO:   n_state = ST_MUL_HI;
            ST_MUL_HI:   n_state = ST_FINISH;
            ST_FINISH:   n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake, divider start, multiplier operands
    always_comb begin
        o_ready     = 1'b0;
        w_div_start = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        case (r_state)
            ST_IDLE:   o_ready = 1'b1;
            ST_AVG_A: begin
                w_mul_a = 32'(KEEP_Q16);
                w_mul_b = r_smooth;
            end
            ST_AVG_B: begin
                w_mul_a = 32'(ALPHA_Q16);
                w_mul_b = {r_meas, 8'h00};
            end
            ST_DEN: begin
                w_mul_a = 32'(w_fps);
                w_mul_b = r_smooth;
            end
            ST_DIV_GO: w_div_start = 1'b1;
            ST_MUL_V: begin
                w_mul_a = r_ratio;
                w_mul_b = 24'(r_spp);
            end
            ST_MUL_LO: begin
                w_mul_a = 32'(STEP_DOWN_Q16);
                w_mul_b = 24'(r_spp);
            end
            ST_MUL_HI: begin
                w_mul_a = 32'(STEP_UP_Q16);
                w_mul_b = 24'(r_spp);
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_enable     <= 1'b1;
            r_target_fps <= FPS_DEFAULT;
            r_smooth     <= '0;
            r_holdoff    <= '0;
            r_spp        <= SPP_W'(8);
            r_fast_cnt   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ENABLE:     r_enable     <= i_cfg_data[0];
                    CFG_TARGET_FPS: r_target_fps <= i_cfg_data;
                    default:        r_enable     <= r_enable;
                endcase
            end

            case (r_state)
                ST_CHECK: begin
                    if (!r_enable || w_meas == '0) begin
                        r_fast_cnt <= w_fast_eff;
                    end else begin
                        r_fast_cnt <= (w_fast_eff != 8'd0) ? (w_fast_eff - 1'b1) : w_fast_eff;
                        if (w_fast_eff != 8'd0 || r_smooth == '0) begin
                            r_smooth <= {w_meas, 8'h00};
                        end
                    end
                end
                ST_AVG_B: r_smooth <= w_avg_sum[39:16];
                ST_HOLD: begin
                    if (!r_fast && r_holdoff != '0) begin
                        r_holdoff <= r_holdoff - 1'b1;
                    end
                end
                ST_FINISH: begin
                    r_spp     <= w_next;
                    r_holdoff <= r_fast ? 7'd0 : w_hold;
                end
                default: begin
                    r_spp <= r_spp;
                end
            endcase

            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_render <= i_render_time;
            r_frame  <= i_frame_time;
            r_load   <= i_fast_adapt_load;
        end
        case (r_state)
            ST_CHECK: begin
                r_meas        <= w_meas;
                r_fast        <= w_fast_eff != 8'd0;
                r_res_changed <= 1'b0;
                if (!r_enable) begin
                    r_res_status <= STAT_DISABLED;
                end else begin
                    r_res_status <= STAT_NO_MEAS;
                end
            end
            ST_AVG_A: r_acc <= w_prod[39:0];
            ST_HOLD:  r_res_status <= STAT_HOLDOFF;
            ST_DEN:   r_den <= w_prod[DIV_DEN_W-1:0];
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    r_ratio <= (w_quo[DIV_NUM_W-1:32] != '0) ? 32'hFFFF_FFFF : w_quo[31:0];
                end
            end
            ST_BAND:  r_res_status <= STAT_DEAD_BAND;
            ST_MUL_V: r_v <= w_prod[43:0];
            // step limits, skipped in fast adapt
            ST_MUL_LO: begin
                if (!r_fast && w_prod[43:0] > r_v) begin
                    r_v <= w_prod[43:0];
                end
            end
            ST_MUL_HI: begin
                if (!r_fast && w_prod[43:0] < r_v) begin
                    r_v <= w_prod[43:0];
                end
            end
            ST_FINISH: begin
                r_res_status  <= STAT_ADJUSTED;
                r_res_changed <= w_next != r_spp;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    r_out_spp     <= r_spp;
                    r_out_changed <= r_res_changed;
                    r_out_status  <= r_res_status;
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_valid             = r_out_valid;
    assign o_samples_per_pixel = r_out_spp;
    assign o_changed           = r_out_changed;
    assign o_status            = r_out_status;

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// testbench for the sample count rate controller: directed and random frames against a predictor
`timescale 1ns / 100ps

module tb;
    import scrc_pkg::*;

    localparam int SPP_MAX        = 2048;
    localparam int QUIET_LIMIT    = 4000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int MAX_REPORTS    = 10;

    localparam logic [63:0] Q16_ONE       = 64'd65536;
    localparam logic [63:0] Q16_ALPHA     = 64'd5243;
    localparam logic [63:0] Q16_KEEP      = 64'd60293;
    localparam logic [63:0] Q16_STEP_DOWN = 64'd60293;
    localparam logic [63:0] Q16_STEP_UP   = 64'd73400;
    localparam logic [63:0] Q16_DEAD_BAND = 64'd6554;
    // budget numerator: 0.95 * 1000 ms in q16 of the q8 smoothed unit
    localparam logic [63:0] BUDGET_Q32    = 64'd950 << 32;

    typedef struct {
        logic [11:0] spp;
        logic        changed;
        t_status     status;
    } t_spp_result;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [15:0] i_render_time = '0;
    logic [15:0] i_frame_time = '0;
    logic [7:0]  i_fast_adapt_load = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [11:0] o_samples_per_pixel;
    logic        o_changed;
    logic [2:0]  o_status;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_ENABLE;
    logic [8:0]  i_cfg_data = '0;

    sample_count_rate_controller #(
        .MAX_SAMPLES(SPP_MAX)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_render_time      (i_render_time),
        .i_frame_time       (i_frame_time),
        .i_fast_adapt_load  (i_fast_adapt_load),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_samples_per_pixel(o_samples_per_pixel),
        .o_changed          (o_changed),
        .o_status           (o_status),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // controller state as predicted, reset values
    logic        m_enable = 1'b1;
    logic [8:0]  m_fps = 9'd60;
    logic [23:0] m_smooth = '0;
    logic [6:0]  m_hold = '0;
    logic [11:0] m_spp = 12'd8;
    logic [7:0]  m_fast = '0;

    t_spp_result expected_spp_q[$];
    int          src_idle_pct = 8;
    int          sink_idle_pct = 45;
    int          frames_sent = 0;
    int          results_seen = 0;
    int          failures = 0;
    int          count_changes = 0;
    int          status_seen[5] = '{default: 0};
    int          quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_spp_result predict_frame(input logic [15:0] render,
                                                  input logic [15:0] frame,
                                                  input logic [7:0] load);
        t_spp_result res;
        logic [15:0] meas;
        logic        fast_now;
        logic [63:0] acc, den, ratio, diff, v, lo, hi, new_spp;
        int unsigned fps_eff, hold_len;
        if (load != 0)
            m_fast = load;
        res.spp     = m_spp;
        res.changed = 1'b0;
        res.status  = STAT_DISABLED;
        if (!m_enable)
            return res;
        meas = (render != 0) ? render : frame;
        res.status = STAT_NO_MEAS;
        if (meas == 0)
            return res;
        fast_now = (m_fast != 0);
        if (fast_now)
            m_fast = m_fast - 8'd1;
        if (fast_now || m_smooth == 0) begin
            m_smooth = {meas, 8'h00};
        end else begin
            acc = 64'(m_smooth) * Q16_KEEP + (64'(meas) << 8) * Q16_ALPHA + 64'd32768;
            m_smooth = acc[39:16];
        end
        res.status = STAT_HOLDOFF;
        if (!fast_now && m_hold != 0) begin
            m_hold = m_hold - 7'd1;
            return res;
        end
        fps_eff = (m_fps != 0) ? m_fps : 60;
        den = 64'(fps_eff) * 64'(m_smooth);
        if (den == 0)
            den = 64'd1;
        ratio = (BUDGET_Q32 + den / 2) / den;
        if (ratio > 64'hFFFF_FFFF)
            ratio = 64'hFFFF_FFFF;
        diff = (ratio >= Q16_ONE) ? ratio - Q16_ONE : Q16_ONE - ratio;
        res.status = STAT_DEAD_BAND;
        if (diff < Q16_DEAD_BAND)
            return res;
        v = 64'(m_spp) * ratio;
        if (!fast_now) begin
            lo = 64'(m_spp) * Q16_STEP_DOWN;
            hi = 64'(m_spp) * Q16_STEP_UP;
            if (v < lo) v = lo;
            if (v > hi) v = hi;
        end
        if (v < Q16_ONE)
            v = Q16_ONE;
        if (v > (64'(SPP_MAX) << 16))
            v = 64'(SPP_MAX) << 16;
        new_spp = (v + 64'd32768) >> 16;
        if (new_spp > SPP_MAX)
            new_spp = SPP_MAX;
        // rounding left the count where it was: move it one step toward the ratio
        if (new_spp == m_spp && ratio > Q16_ONE && m_spp < SPP_MAX)
            new_spp = m_spp + 1;
        if (new_spp == m_spp && ratio < Q16_ONE && m_spp > 1)
            new_spp = m_spp - 1;
        if (!fast_now) begin
            hold_len = fps_eff / 5;
            if (hold_len < 6)
                hold_len = 6;
            m_hold = hold_len[6:0];
        end else begin
            m_hold = '0;
        end
        res.changed = (new_spp[11:0] != m_spp);
        res.status  = STAT_ADJUSTED;
        m_spp       = new_spp[11:0];
        res.spp     = m_spp;
        return res;
    endfunction

    // frame time that scales with the current count, so the loop can settle near goal
    function automatic logic [15:0] workload_time(input int unsigned goal);
        longint unsigned t;
        int unsigned fps_eff;
        fps_eff = (m_fps != 0) ? m_fps : 60;
        t = 243200 / fps_eff;
        t = t * m_spp * $urandom_range(90, 110);
        t = t / (goal * 100);
        if (t == 0)
            t = 1;
        if (t > 65535)
            t = 65535;
        return t[15:0];
    endfunction

    function automatic logic [8:0] pick_fps();
        case ($urandom_range(5))
            0: return 9'd0;
            1: return 9'd1;
            2: return 9'd360;
            default: return 9'($urandom_range(2, 359));
        endcase
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("[%0t] error: %s", $realtime, msg);
    endtask

    task automatic send_frame(input logic [15:0] render, input logic [15:0] frame,
                              input logic [7:0] load);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_render_time     <= render;
        i_frame_time      <= frame;
        i_fast_adapt_load <= load;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        expected_spp_q.push_back(predict_frame(render, frame, load));
        frames_sent++;
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (expected_spp_q.size() != 0);
    endtask

    // only called with no beat in flight
    task automatic set_config(input logic enable, input logic [8:0] fps);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_ENABLE;
        i_cfg_data  <= {8'd0, enable};
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_index <= CFG_TARGET_FPS;
        i_cfg_data  <= fps;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        m_enable = enable;
        m_fps    = fps;
    endtask

    task automatic test_measurement_basics();
        set_config(1'b1, 9'd0);
        send_frame(16'd0, 16'd0, 8'd0);
        send_frame(16'd0, 16'd2000, 8'd0);
        send_frame(16'd2000, 16'd0, 8'd0);
        send_frame(16'd65535, 16'd1, 8'd0);
        wait_results_drained();
    endtask

    task automatic test_fast_adapt();
        send_frame(16'd40000, 16'd0, 8'd3);
        send_frame(16'd1, 16'd0, 8'd0);
        send_frame(16'd4053, 16'd0, 8'd0);
        send_frame(16'd4053, 16'd0, 8'd0);
        wait_results_drained();
    endtask

    task automatic test_disabled();
        set_config(1'b0, 9'd360);
        send_frame(16'd1000, 16'd1000, 8'd0);
        send_frame(16'd0, 16'd0, 8'd2);
        send_frame(16'd65535, 16'd65535, 8'd0);
        wait_results_drained();
        set_config(1'b1, 9'd360);
        send_frame(16'd675, 16'd0, 8'd0);
        // count already at its cap, so the adjustment leaves it unchanged
        send_frame(16'd300, 16'd0, 8'd0);
        wait_results_drained();
    endtask

    task automatic test_step_limits();
        send_frame(16'd65535, 16'd0, 8'd1);
        send_frame(16'd800, 16'd0, 8'd0);
        send_frame(16'd800, 16'd0, 8'd0);
        wait_results_drained();
        set_config(1'b1, 9'd1);
        send_frame(16'd1, 16'd0, 8'd0);
        send_frame(16'd0, 16'd1, 8'd0);
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        int unsigned goal, sel;
        logic [15:0] t;
        for (int mode = 0; mode < 3; mode++) begin
            src_idle_pct  = (mode == 0) ? 8 : (mode == 1) ? 45 : 0;
            sink_idle_pct = (mode == 0) ? 45 : (mode == 1) ? 8 : 0;
            for (int chunk = 0; chunk < 4; chunk++) begin
                wait_results_drained();
                set_config($urandom_range(9) != 0, pick_fps());
                goal = ($urandom_range(3) == 0) ? $urandom_range(200, 2048)
                                                : $urandom_range(1, 64);
                for (int n = 0; n < 33; n++) begin
                    if ($urandom_range(49) == 0)
                        wait_results_drained();
                    sel = $urandom_range(99);
                    t = workload_time(goal);
                    if (sel < 3)
                        send_frame(16'd0, 16'd0, 8'd0);
                    else if (sel < 13)
                        send_frame(16'($urandom), 16'($urandom), 8'($urandom));
                    else if (sel < 30)
                        send_frame(16'd0, t, 8'd0);
                    else
                        send_frame(t, 16'($urandom),
                                   ($urandom_range(39) == 0) ? 8'($urandom_range(1, 6)) : 8'd0);
                end
            end
        end
    endtask

    task automatic test_full_fast_load();
        wait_results_drained();
        set_config(1'b1, 9'd60);
        send_frame(16'd65535, 16'd65535, 8'd255);
        send_frame(16'd1, 16'd0, 8'd0);
        send_frame(16'd0, 16'd65535, 8'd0);
        send_frame(16'd4053, 16'd0, 8'd0);
        for (int n = 0; n < 4; n++)
            send_frame(16'($urandom), 16'($urandom), 8'd0);
        wait_results_drained();
    endtask

    // receiver side
    always @(posedge i_clk)
        i_ready <= ($urandom_range(99) >= sink_idle_pct);

    always @(posedge i_clk) begin
        t_spp_result exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (o_status < 5)
                status_seen[o_status]++;
            if (o_changed)
                count_changes++;
            if (expected_spp_q.size() == 0) begin
                note_failure($sformatf("unexpected result beat: spp %0d changed %0d status %0d",
                                       o_samples_per_pixel, o_changed, o_status));
            end else begin
                exp_res = expected_spp_q.pop_front();
                if (o_samples_per_pixel !== exp_res.spp || o_changed !== exp_res.changed ||
                    o_status !== exp_res.status)
                    note_failure($sformatf({"result %0d: expected spp %0d changed %0d status %0d,",
                                            " got spp %0d changed %0d status %0d"},
                                           results_seen, exp_res.spp, exp_res.changed,
                                           exp_res.status, o_samples_per_pixel, o_changed,
                                           o_status));
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_measurement_basics();
        test_fast_adapt();
        test_disabled();
        test_step_limits();
        test_random_traffic();
        test_full_fast_load();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_spp_q.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_spp_q.size()));
        $display("covered %0d frames over enable, fps and idle settings, %0d results checked",
                 frames_sent, results_seen);
        $display("status mix: %0d off, %0d no meas, %0d hold, %0d band, %0d adj, %0d changes",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], count_changes);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d failures", failures);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
